>>> design/aho_corasick_occurrence_counter_defines.svh
// assertion macros used by the occurrence counter top level
`ifndef AHO_CORASICK_OCCURRENCE_COUNTER_DEFINES_SVH
`define AHO_CORASICK_OCCURRENCE_COUNTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ACOC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ACOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/acoc_pkg.sv
// shared types, constants and codes of the occurrence counter
`default_nettype none
package acoc_pkg;

    localparam int NODES_DEF    = 1024;
    localparam int ALPHABET_DEF = 26;
    localparam int MAX_LEN_DEF  = 6;
    localparam int COUNT_W_DEF  = 32;

    localparam int POS_W       = 32;
    localparam int NODE_ID_W   = 10;
    localparam int COUNT_OUT_W = 32;
    localparam int FUNC_W      = 3;
    localparam int SYM_W       = 5;

    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PATTERN = 3'd1;
    localparam logic [FUNC_W-1:0] FN_BUILD   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TEXT    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [SYM_W-1:0]     symbol;
        logic                 last_symbol;
        logic [NODE_ID_W-1:0] query_node;
        logic                 non_overlap;
    } t_in;

    typedef struct packed {
        logic [NODE_ID_W-1:0]   node_id;
        logic [COUNT_OUT_W-1:0] count;
        logic                   status;
    } t_out;

    typedef enum logic [4:0] {
        ST_BOOT, ST_IDLE, ST_DECODE, ST_CLR_INIT, ST_CLR_ROW,
        ST_PAT_RD, ST_PAT_CHK, ST_PAT_ZERO, ST_PAT_END,
        ST_BLD_INIT, ST_BR_RD, ST_BR_U, ST_BR_CHK,
        ST_BQ_HEAD, ST_BQ_R, ST_BQ_FR,
        ST_BC_RD1, ST_BC_RD2, ST_BC_RD3, ST_BC_CHK, ST_BLD_END,
        ST_T_RD, ST_T_M, ST_T_J, ST_T_LOOP, ST_T_UPD, ST_T_END,
        ST_Q_RD, ST_Q_RES, ST_RESP
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_CLR_INIT, OP_CLR_ROW,
        OP_PAT_RD, OP_PAT_CHK, OP_PAT_ZERO, OP_PAT_END,
        OP_BLD_INIT, OP_BR_RD, OP_BR_U, OP_BR_CHK,
        OP_BQ_HEAD, OP_BQ_R, OP_BQ_FR,
        OP_BC_RD1, OP_BC_RD2, OP_BC_RD3, OP_BC_CHK, OP_BLD_END,
        OP_T_RD, OP_T_M, OP_T_J, OP_T_LOOP, OP_T_UPD, OP_T_END,
        OP_Q_RD, OP_Q_RES
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              sym_ok;
        logic              qn_ok;
        logic              pat_skip;
        logic              grow;
        logic              col_last;
        logic              queue_busy;
        logic              chain_done;
    } t_stat;

endpackage
`default_nettype wire

>>> design/aho_corasick_occurrence_counter.sv
// top level of the multi-pattern occurrence counter
// usage:
//   one request channel (i_valid/o_ready, payload i_data) and one result
//   channel (o_valid/i_ready, payload o_data); every request gives exactly one result
//   requests: clear, pattern symbol, build links, text symbol, query count
//   requests are worked one at a time; o_ready is high only while idle
// work behind each result:
//   query, unused code, out-of-range symbol: no table walk
//   pattern symbol: a goto read, plus a row wipe when it allocates a node
//   pattern symbol skipped (pattern too long or store full): no goto access
//   clear: a wipe of the root row
//   text symbol: a goto step, plus a count update per pattern found on the output-link chain
//   build: a scan of the root row, then a scan of the row of each queued trie node
//   each node memory has a single read port
// reset: a clearing pass wipes the root row of the
//   goto memory; no request is taken until it ends
// a finished result sits in the output register; the next request is
//   accepted while it waits, and its own result waits until i_ready
`default_nettype none
`include "aho_corasick_occurrence_counter_defines.svh"
module aho_corasick_occurrence_counter import acoc_pkg::*; #(
    parameter int NODES           = NODES_DEF,
    parameter int ALPHABET        = ALPHABET_DEF,
    parameter int MAX_PATTERN_LEN = MAX_LEN_DEF,
    parameter int COUNT_WIDTH     = COUNT_W_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    // command and status between sequencer and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    acoc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    acoc_dp #(
        .NODES           (NODES),
        .ALPHABET        (ALPHABET),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_data  (o_data)
    );

    // one request in flight at a time
    `ACOC_ASSERT_NEXT(a_single_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second request taken while busy")
    // a result never overwrites one still waiting
    `ACOC_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.load_out, !o_valid || i_ready, "result register overwritten")
    // a loaded result shows up on the port
    `ACOC_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_cmd.load_out, o_valid, "loaded result not presented")

endmodule
`default_nettype wire

>>> design/acoc_ram.sv
// generic single write port ram with registered read
`default_nettype none
module acoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> design/acoc_ctrl.sv
// sequencing state machine of the occurrence counter
`default_nettype none
module acoc_ctrl import acoc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BOOT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            ST_BOOT: begin
                o_cmd.op = OP_CLR_ROW;
                if (i_stat.col_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.func)
                    FN_CLEAR:   n_state = ST_CLR_INIT;
                    FN_PATTERN: n_state = !i_stat.sym_ok ? ST_RESP :
                                          (i_stat.pat_skip ? ST_PAT_END : ST_PAT_RD);
                    FN_BUILD:   n_state = ST_BLD_INIT;
                    FN_TEXT:    n_state = i_stat.sym_ok ? ST_T_RD : ST_RESP;
                    FN_QUERY:   n_state = i_stat.qn_ok ? ST_Q_RD : ST_RESP;
                    default:    n_state = ST_RESP;
                endcase
            end
            ST_CLR_INIT: begin
                o_cmd.op = OP_CLR_INIT;
                n_state  = ST_CLR_ROW;
            end
            ST_CLR_ROW: begin
                o_cmd.op = OP_CLR_ROW;
                if (i_stat.col_last) n_state = ST_RESP;
            end
            ST_PAT_RD: begin
                o_cmd.op = OP_PAT_RD;
                n_state  = ST_PAT_CHK;
            end
            ST_PAT_CHK: begin
                o_cmd.op = OP_PAT_CHK;
                n_state  = i_stat.grow ? ST_PAT_ZERO : ST_PAT_END;
            end
            ST_PAT_ZERO: begin
                o_cmd.op = OP_PAT_ZERO;
                if (i_stat.col_last) n_state = ST_PAT_END;
            end
            ST_PAT_END: begin
                o_cmd.op = OP_PAT_END;
                n_state  = ST_RESP;
            end
            ST_BLD_INIT: begin
                o_cmd.op = OP_BLD_INIT;
                n_state  = ST_BR_RD;
            end
            ST_BR_RD: begin
                o_cmd.op = OP_BR_RD;
                n_state  = ST_BR_U;
            end
            ST_BR_U: begin
                o_cmd.op = OP_BR_U;
                n_state  = ST_BR_CHK;
            end
            ST_BR_CHK: begin
                o_cmd.op = OP_BR_CHK;
                n_state  = i_stat.col_last ? ST_BQ_HEAD : ST_BR_RD;
            end
            ST_BQ_HEAD: begin
                o_cmd.op = OP_BQ_HEAD;
                n_state  = i_stat.queue_busy ? ST_BQ_R : ST_BLD_END;
            end
            ST_BQ_R: begin
                o_cmd.op = OP_BQ_R;
                n_state  = ST_BQ_FR;
            end
            ST_BQ_FR: begin
                o_cmd.op = OP_BQ_FR;
                n_state  = ST_BC_RD1;
            end
            ST_BC_RD1: begin
                o_cmd.op = OP_BC_RD1;
                n_state  = ST_BC_RD2;
            end
            ST_BC_RD2: begin
                o_cmd.op = OP_BC_RD2;
                n_state  = ST_BC_RD3;
            end
            ST_BC_RD3: begin
                o_cmd.op = OP_BC_RD3;
                n_state  = ST_BC_CHK;
            end
            ST_BC_CHK: begin
                o_cmd.op = OP_BC_CHK;
                n_state  = i_stat.col_last ? ST_BQ_HEAD : ST_BC_RD1;
            end
            ST_BLD_END: begin
                o_cmd.op = OP_BLD_END;
                n_state  = ST_RESP;
            end
            ST_T_RD: begin
                o_cmd.op = OP_T_RD;
                n_state  = ST_T_M;
            end
            ST_T_M: begin
                o_cmd.op = OP_T_M;
                n_state  = ST_T_J;
            end
            ST_T_J: begin
                o_cmd.op = OP_T_J;
                n_state  = ST_T_LOOP;
            end
            ST_T_LOOP: begin
                o_cmd.op = OP_T_LOOP;
                n_state  = i_stat.chain_done ? ST_T_END : ST_T_UPD;
            end
            ST_T_UPD: begin
                o_cmd.op = OP_T_UPD;
                n_state  = ST_T_LOOP;
            end
            ST_T_END: begin
                o_cmd.op = OP_T_END;
                n_state  = ST_RESP;
            end
            ST_Q_RD: begin
                o_cmd.op = OP_Q_RD;
                n_state  = ST_Q_RES;
            end
            ST_Q_RES: begin
                o_cmd.op = OP_Q_RES;
                n_state  = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

>>> design/acoc_dp.sv
// trie, link and count memories with their registers
`default_nettype none
module acoc_dp import acoc_pkg::*; #(
    parameter int NODES           = NODES_DEF,
    parameter int ALPHABET        = ALPHABET_DEF,
    parameter int MAX_PATTERN_LEN = MAX_LEN_DEF,
    parameter int COUNT_WIDTH     = COUNT_W_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_data,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_out  o_data
);

    localparam int NW = $clog2(NODES);
    localparam int AW = $clog2(ALPHABET);
    localparam int DW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int GD = NODES * ALPHABET;
    localparam int GW = $clog2(GD);
    localparam int LW = POS_W + 1;
    localparam int CW = COUNT_WIDTH;

    function automatic logic [GW-1:0] f_slot(input logic [NW-1:0] node,
                                             input logic [AW-1:0] col);
        return GW'(32'(node) * 32'(ALPHABET) + 32'(col));
    endfunction

    function automatic logic [CW-1:0] f_sat(input logic [CW-1:0] v);
        return (&v) ? v : v + CW'(1);
    endfunction

    // request and result
    t_in  r_req;
    t_out r_res, r_out;

    // control state
    logic [NW:0]       r_nodes_used;
    logic [NW-1:0]     r_cursor;
    logic [DW-1:0]     r_ins_depth;
    logic              r_ins_fail;
    logic [NW-1:0]     r_match;
    logic [POS_W-1:0]  r_pos;
    logic [AW-1:0]     r_col;
    logic [NW:0]       r_head, r_tail, r_steps;

    // working registers
    logic [NW-1:0] r_node_r, r_fr, r_u, r_via, r_j;
    logic [DW-1:0] r_dr;

    // memory ports
    logic [NW-1:0] w_goto_rd, w_fail_rd, w_olink_rd, w_queue_rd;
    logic [DW-1:0] w_depth_rd;
    logic          w_term_rd;
    logic [CW-1:0] w_all_rd, w_dis_rd;
    logic [LW-1:0] w_last_rd;

    logic          w_goto_we;
    logic [GW-1:0] w_goto_wa, w_goto_ra;
    logic [NW-1:0] w_goto_wd;
    logic [NW-1:0] w_nwa;
    logic          w_fail_we, w_olink_we, w_depth_we, w_term_we;
    logic          w_all_we, w_dis_we, w_last_we, w_queue_we;
    logic [NW-1:0] w_fail_wd, w_olink_wd, w_queue_wd;
    logic [DW-1:0] w_depth_wd;
    logic          w_term_wd;
    logic [CW-1:0] w_all_wd, w_dis_wd;
    logic [LW-1:0] w_last_wd;
    logic [NW-1:0] w_fail_ra, w_depth_ra, w_link_ra, w_cnt_ra, w_queue_wa, w_queue_ra;

    logic [AW-1:0] w_sym_col;
    logic          w_full, w_grow, w_col_last;
    logic          w_root_child, w_child;
    logic [NW-1:0] w_olink_new, w_j_first;
    logic signed [POS_W+1:0] w_here, w_prev, w_dist;
    logic          w_gap_ok;
    logic [CW-1:0] w_qcnt;
    logic [COUNT_OUT_W-1:0] w_count_out;

    assign w_sym_col  = AW'(r_req.symbol);
    assign w_full     = 32'(r_nodes_used) >= NODES;
    assign w_grow     = (w_goto_rd == '0) && !w_full;
    assign w_col_last = 32'(r_col) == ALPHABET - 1;

    // a child is a live node one level below the row being scanned
    assign w_root_child = (r_u != '0) && ((NW+1)'(r_u) < r_nodes_used) &&
                          (w_depth_rd == DW'(1)) && (32'(r_tail) < NODES);
    assign w_child = (r_u != '0) && ((NW+1)'(r_u) < r_nodes_used) &&
                     ((DW+1)'(w_depth_rd) == (DW+1)'(r_dr) + (DW+1)'(1)) &&
                     (32'(r_tail) < NODES);

    // root entries of the link stores are never written, read them as zero
    assign w_olink_new = (r_via == '0) ? '0 : (w_term_rd ? r_via : w_olink_rd);
    assign w_j_first   = (r_match == '0) ? '0 : (w_term_rd ? r_match : w_olink_rd);

    assign w_here   = signed'({2'b00, r_pos});
    assign w_prev   = signed'({w_last_rd[LW-1], w_last_rd});
    assign w_dist   = w_here - w_prev;
    assign w_gap_ok = w_dist >= signed'((POS_W+2)'(w_depth_rd));

    assign w_qcnt      = r_req.non_overlap ? w_dis_rd : w_all_rd;
    assign w_count_out = (CW > COUNT_OUT_W && (w_qcnt >> COUNT_OUT_W) != '0) ?
                         '1 : COUNT_OUT_W'(w_qcnt);

    always_comb begin
        o_stat.func       = r_req.func;
        o_stat.sym_ok     = 32'(r_req.symbol) < ALPHABET;
        o_stat.qn_ok      = (32'(r_req.query_node) < NODES) && (r_req.query_node != '0) &&
                            (32'(r_req.query_node) < 32'(r_nodes_used));
        o_stat.pat_skip   = r_ins_fail || !(32'(r_ins_depth) < MAX_PATTERN_LEN);
        o_stat.grow       = w_grow;
        o_stat.col_last   = w_col_last;
        o_stat.queue_busy = r_head < r_tail;
        o_stat.chain_done = (r_j == '0) || (32'(r_steps) >= NODES);
    end

    // memory port steering
    always_comb begin
        w_goto_we  = 1'b0;
        w_goto_wa  = f_slot(r_cursor, w_sym_col);
        w_goto_wd  = '0;
        w_goto_ra  = f_slot(r_cursor, w_sym_col);
        w_nwa      = r_j;
        w_fail_we  = 1'b0;
        w_olink_we = 1'b0;
        w_depth_we = 1'b0;
        w_term_we  = 1'b0;
        w_all_we   = 1'b0;
        w_dis_we   = 1'b0;
        w_last_we  = 1'b0;
        w_queue_we = 1'b0;
        w_fail_wd  = '0;
        w_olink_wd = '0;
        w_depth_wd = r_ins_depth + DW'(1);
        w_term_wd  = 1'b0;
        w_all_wd   = '0;
        w_dis_wd   = '0;
        w_last_wd  = '1;
        w_queue_wd = r_u;
        w_queue_wa = NW'(r_tail);
        w_queue_ra = NW'(r_head);
        w_fail_ra  = w_queue_rd;
        w_depth_ra = r_j;
        w_link_ra  = r_j;
        w_cnt_ra   = r_j;
        unique case (i_cmd.op)
            OP_CLR_ROW: begin
                w_goto_we = 1'b1;
                w_goto_wa = f_slot('0, r_col);
            end
            OP_PAT_CHK: begin
                if (w_grow) begin
                    // new node: link it in and initialize its entries
                    w_goto_we  = 1'b1;
                    w_goto_wd  = NW'(r_nodes_used);
                    w_nwa      = NW'(r_nodes_used);
                    w_fail_we  = 1'b1;
                    w_olink_we = 1'b1;
                    w_term_we  = 1'b1;
                    w_depth_we = 1'b1;
                    w_all_we   = 1'b1;
                    w_dis_we   = 1'b1;
                    w_last_we  = 1'b1;
                end
            end
            OP_PAT_ZERO: begin
                w_goto_we = 1'b1;
                w_goto_wa = f_slot(r_cursor, r_col);
            end
            OP_PAT_END: begin
                if (r_req.last_symbol && !r_ins_fail) begin
                    w_nwa     = r_cursor;
                    w_term_we = 1'b1;
                    w_term_wd = 1'b1;
                end
            end
            OP_BR_RD: w_goto_ra = f_slot('0, r_col);
            OP_BR_U:  w_depth_ra = w_goto_rd;
            OP_BR_CHK: begin
                if (w_root_child) begin
                    w_nwa      = r_u;
                    w_fail_we  = 1'b1;
                    w_olink_we = 1'b1;
                    w_queue_we = 1'b1;
                end
            end
            OP_BQ_R: begin
                w_fail_ra  = w_queue_rd;
                w_depth_ra = w_queue_rd;
            end
            OP_BC_RD1: w_goto_ra = f_slot(r_node_r, r_col);
            OP_BC_RD2: w_goto_ra = f_slot(r_fr, r_col);
            OP_BC_RD3: begin
                w_depth_ra = r_u;
                w_link_ra  = w_goto_rd;
            end
            OP_BC_CHK: begin
                if (w_child) begin
                    w_nwa      = r_u;
                    w_fail_we  = 1'b1;
                    w_fail_wd  = r_via;
                    w_olink_we = 1'b1;
                    w_olink_wd = w_olink_new;
                    w_queue_we = 1'b1;
                end else begin
                    // missing edge becomes the failure target's edge
                    w_goto_we = 1'b1;
                    w_goto_wa = f_slot(r_node_r, r_col);
                    w_goto_wd = r_via;
                end
            end
            OP_T_RD: w_goto_ra = f_slot(r_match, w_sym_col);
            OP_T_M:  w_link_ra = w_goto_rd;
            OP_T_UPD: begin
                w_all_we = 1'b1;
                w_all_wd = f_sat(w_all_rd);
                if (w_gap_ok) begin
                    w_dis_we  = 1'b1;
                    w_dis_wd  = f_sat(w_dis_rd);
                    w_last_we = 1'b1;
                    w_last_wd = {1'b0, r_pos};
                end
            end
            OP_Q_RD: w_cnt_ra = NW'(r_req.query_node);
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_used <= (NW+1)'(1);
            r_cursor     <= '0;
            r_ins_depth  <= '0;
            r_ins_fail   <= 1'b0;
            r_match      <= '0;
            r_pos        <= '0;
            r_col        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_steps      <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_CLR_INIT: begin
                    r_nodes_used <= (NW+1)'(1);
                    r_cursor     <= '0;
                    r_ins_depth  <= '0;
                    r_ins_fail   <= 1'b0;
                    r_match      <= '0;
                    r_pos        <= '0;
                    r_col        <= '0;
                end
                OP_CLR_ROW, OP_PAT_ZERO: begin
                    r_col <= w_col_last ? '0 : r_col + AW'(1);
                end
                OP_PAT_CHK: begin
                    r_col <= '0;
                    if (w_goto_rd != '0) begin
                        r_cursor    <= w_goto_rd;
                        r_ins_depth <= r_ins_depth + DW'(1);
                    end else if (w_full) begin
                        r_ins_fail <= 1'b1;
                    end else begin
                        r_nodes_used <= r_nodes_used + (NW+1)'(1);
                        r_cursor     <= NW'(r_nodes_used);
                        r_ins_depth  <= r_ins_depth + DW'(1);
                    end
                end
                OP_PAT_END: begin
                    if (r_req.last_symbol) begin
                        r_cursor    <= '0;
                        r_ins_depth <= '0;
                        r_ins_fail  <= 1'b0;
                    end
                end
                OP_BLD_INIT: begin
                    r_head <= '0;
                    r_tail <= '0;
                    r_col  <= '0;
                end
                OP_BR_CHK: begin
                    r_col <= w_col_last ? '0 : r_col + AW'(1);
                    if (w_root_child) r_tail <= r_tail + (NW+1)'(1);
                end
                OP_BQ_HEAD: begin
                    if (r_head < r_tail) r_head <= r_head + (NW+1)'(1);
                end
                OP_BC_CHK: begin
                    r_col <= w_col_last ? '0 : r_col + AW'(1);
                    if (w_child) r_tail <= r_tail + (NW+1)'(1);
                end
                OP_BLD_END: r_match <= '0;
                OP_T_M:     r_match <= w_goto_rd;
                OP_T_J:     r_steps <= '0;
                OP_T_UPD:   r_steps <= r_steps + (NW+1)'(1);
                OP_T_END: begin
                    if (r_pos != '1) r_pos <= r_pos + POS_W'(1);
                end
                default: ;
            endcase
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_req <= i_data;
                r_res <= '0;
            end
            OP_BR_U:   r_u <= w_goto_rd;
            OP_BQ_R:   r_node_r <= w_queue_rd;
            OP_BQ_FR: begin
                r_fr <= w_fail_rd;
                r_dr <= w_depth_rd;
            end
            OP_BC_RD2: r_u <= w_goto_rd;
            OP_BC_RD3: r_via <= w_goto_rd;
            OP_T_J:    r_j <= w_j_first;
            OP_T_UPD:  r_j <= w_olink_rd;
            OP_PAT_END: begin
                r_res.status <= r_ins_fail;
                if (r_req.last_symbol && !r_ins_fail) begin
                    r_res.node_id <= NODE_ID_W'(r_cursor);
                end
            end
            OP_Q_RES:  r_res.count <= w_count_out;
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_data = r_out;

    acoc_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
        .i_clk(i_clk), .i_we(w_goto_we), .i_waddr(w_goto_wa), .i_wdata(w_goto_wd),
        .i_raddr(w_goto_ra), .o_rdata(w_goto_rd)
    );
    acoc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
        .i_clk(i_clk), .i_we(w_fail_we), .i_waddr(w_nwa), .i_wdata(w_fail_wd),
        .i_raddr(w_fail_ra), .o_rdata(w_fail_rd)
    );
    acoc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_olink (
        .i_clk(i_clk), .i_we(w_olink_we), .i_waddr(w_nwa), .i_wdata(w_olink_wd),
        .i_raddr(w_link_ra), .o_rdata(w_olink_rd)
    );
    acoc_ram #(.WIDTH(DW), .DEPTH(NODES)) u_depth (
        .i_clk(i_clk), .i_we(w_depth_we), .i_waddr(w_nwa), .i_wdata(w_depth_wd),
        .i_raddr(w_depth_ra), .o_rdata(w_depth_rd)
    );
    acoc_ram #(.WIDTH(1), .DEPTH(NODES)) u_term (
        .i_clk(i_clk), .i_we(w_term_we), .i_waddr(w_nwa), .i_wdata(w_term_wd),
        .i_raddr(w_link_ra), .o_rdata(w_term_rd)
    );
    acoc_ram #(.WIDTH(CW), .DEPTH(NODES)) u_all (
        .i_clk(i_clk), .i_we(w_all_we), .i_waddr(w_nwa), .i_wdata(w_all_wd),
        .i_raddr(w_cnt_ra), .o_rdata(w_all_rd)
    );
    acoc_ram #(.WIDTH(CW), .DEPTH(NODES)) u_dis (
        .i_clk(i_clk), .i_we(w_dis_we), .i_waddr(w_nwa), .i_wdata(w_dis_wd),
        .i_raddr(w_cnt_ra), .o_rdata(w_dis_rd)
    );
    acoc_ram #(.WIDTH(LW), .DEPTH(NODES)) u_last (
        .i_clk(i_clk), .i_we(w_last_we), .i_waddr(w_nwa), .i_wdata(w_last_wd),
        .i_raddr(w_cnt_ra), .o_rdata(w_last_rd)
    );
    acoc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
        .i_clk(i_clk), .i_we(w_queue_we), .i_waddr(w_queue_wa), .i_wdata(w_queue_wd),
        .i_raddr(w_queue_ra), .o_rdata(w_queue_rd)
    );

endmodule
`default_nettype wire
